// ===== sv/soot_pkg.sv =====
// Types and codes shared by the section offset translator and its cells.
// No dependencies.
`timescale 1ns / 1ps

package soot_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR     = 2'd0,
        ACT_INSERT    = 2'd1,
        ACT_TRANSLATE = 2'd2,
        ACT_SAME      = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_COVERED = 2'd1,
        ST_FULL        = 2'd2
    } status_t;

    // One section held in a cell
    typedef struct packed {
        logic [31:0] off;
        logic [31:0] va;
        logic [31:0] sz;
    } entry_t;

    // Command broadcast to every cell
    typedef struct packed {
        act_t        act;
        logic [31:0] off;
        logic [31:0] va;
        logic [31:0] sz;
        logic [31:0] qa;
        logic [31:0] qb;
        logic [31:0] base;
    } cmd_t;

    // Registered per-cell answer to a query
    typedef struct packed {
        logic        hit;
        logic [31:0] mapped;
        logic        same;
    } cand_t;

endpackage

// ===== sv/soot_cell.sv =====
// One cell of the sorted section chain: holds a section, shifts towards its
// neighbour on a sorted insert and answers translate and range queries.
// Depends on soot_pkg.
`timescale 1ns / 1ps

module soot_cell (
    input  logic            aclk,
    input  soot_pkg::cmd_t  cmd,
    input  logic            upd,
    input  logic            ld,
    input  logic            occ,
    input  soot_pkg::entry_t prev_entry,
    input  logic            prev_gt,
    input  logic            next_le,
    output soot_pkg::entry_t entry,
    output logic            gt,
    output logic            le,
    output soot_pkg::cand_t cand
);
    import soot_pkg::*;

    entry_t      entry_reg, entry_next;
    cand_t       cand_reg, cand_next;
    logic [32:0] lo;
    logic [33:0] hi;
    logic        a_in, b_in;

    // Compare against the broadcast command
    always_comb begin
        gt = !occ || (entry_reg.off > cmd.off);
        le = occ && (cmd.qa >= entry_reg.off);

        // take the neighbour's section or the new one on a sorted insert
        entry_next = entry_reg;
        if (upd && gt) begin
            if (prev_gt) begin
                entry_next = prev_entry;
            end else begin
                entry_next.off = cmd.off;
                entry_next.va  = cmd.va;
                entry_next.sz  = cmd.sz;
            end
        end

        // exact range of the loaded section, no wrap
        lo   = {1'b0, entry_reg.va} + {1'b0, cmd.base};
        hi   = {1'b0, lo} + {2'b00, entry_reg.sz};
        a_in = ({1'b0, cmd.qa} >= lo) && ({2'b00, cmd.qa} < hi);
        b_in = ({1'b0, cmd.qb} >= lo) && ({2'b00, cmd.qb} < hi);

        cand_next.hit    = le && !next_le;
        cand_next.mapped = cmd.qa - entry_reg.off + entry_reg.va + cmd.base;
        cand_next.same   = occ && a_in && b_in;
    end

    // Hold section and candidate
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (ld) begin
            cand_reg <= cand_next;
        end
    end

    assign entry = entry_reg;
    assign cand  = cand_reg;

endmodule

// ===== sv/section_offset_translator.sv =====
// Section offset translator: a result passes through the command register, the
// cell candidate registers and the output register; a new input transfer is taken
// only once the command register frees, which it does once every cell of the chain
// has registered its answer. Reset (synchronous, active low) empties the table and
// clears image_base; section storage is not cleared, so no start-up sweep is needed.
`timescale 1ns / 1ps

module section_offset_translator #(
    parameter int MAX_SECTIONS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sect_file_offset, sect_virt_addr, sect_virt_size, query_a, query_b
    input  logic [159:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // mapped_addr, same_section, zero fill
    output logic [39:0]  m_tdata,
    // status
    output logic [1:0]   m_tuser
);
    import soot_pkg::*;

    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

    logic [31:0]      base_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             cmd_reg, cmd;
    logic             v1_reg, v2_reg, m_valid_reg;
    act_t             act2_reg;
    status_t          stat1, stat2_reg, m_status_reg;
    logic [31:0]      m_mapped_reg, or_mapped;
    logic             m_same_reg, or_same;
    logic             acc, ld, out_load, full, upd;

    entry_t            ent    [MAX_SECTIONS];
    entry_t            prev_e [MAX_SECTIONS];
    cand_t             cand_v [MAX_SECTIONS];
    logic [MAX_SECTIONS-1:0] gt_v, le_v, occ_v, prev_g, next_l;

    assign s_tready = !v1_reg;
    assign acc      = s_tvalid && !v1_reg;
    assign out_load = v2_reg && (!m_valid_reg || m_tready);
    assign ld       = v1_reg && (!v2_reg || out_load);
    assign full     = (count_reg == CNT_W'(MAX_SECTIONS));
    assign upd      = ld && (cmd_reg.act == ACT_INSERT) && !full;

    // Broadcast command with the current load base
    always_comb begin
        cmd      = cmd_reg;
        cmd.base = base_reg;
    end

    // Chain of cells
    for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        assign occ_v[i] = (IDX < count_reg);
        if (i == 0) begin : g_first
            assign prev_e[i] = ent[i];
            assign prev_g[i] = 1'b0;
        end else begin : g_mid
            assign prev_e[i] = ent[i-1];
            assign prev_g[i] = gt_v[i-1];
        end
        if (i == MAX_SECTIONS - 1) begin : g_last
            assign next_l[i] = 1'b0;
        end else begin : g_more
            assign next_l[i] = le_v[i+1];
        end
        soot_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .upd        (upd),
            .ld         (ld),
            .occ        (occ_v[i]),
            .prev_entry (prev_e[i]),
            .prev_gt    (prev_g[i]),
            .next_le    (next_l[i]),
            .entry      (ent[i]),
            .gt         (gt_v[i]),
            .le         (le_v[i]),
            .cand       (cand_v[i])
        );
    end

    // Status of the command leaving the command register
    always_comb begin
        stat1      = ST_OK;
        count_next = count_reg;
        case (cmd_reg.act)
            ACT_CLEAR: begin
                count_next = '0;
            end
            ACT_INSERT: begin
                if (full) begin
                    stat1 = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_TRANSLATE: begin
                if (!le_v[0]) begin
                    stat1 = ST_NOT_COVERED;
                end
            end
            default: begin
                stat1 = ST_OK;
            end
        endcase
    end

    // Merge the one-hot cell answers
    always_comb begin
        or_mapped = '0;
        or_same   = 1'b0;
        for (int j = 0; j < MAX_SECTIONS; j++) begin
            or_mapped = or_mapped | (cand_v[j].hit ? cand_v[j].mapped : 32'd0);
            or_same   = or_same | cand_v[j].same;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            count_reg   <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
            if (ld) begin
                count_reg <= count_next;
            end
            if (acc) begin
                v1_reg <= 1'b1;
            end else if (ld) begin
                v1_reg <= 1'b0;
            end
            if (ld) begin
                v2_reg <= 1'b1;
            end else if (out_load) begin
                v2_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (acc) begin
            cmd_reg.act  <= act_t'(s_tuser);
            cmd_reg.off  <= s_tdata[31:0];
            cmd_reg.va   <= s_tdata[63:32];
            cmd_reg.sz   <= s_tdata[95:64];
            cmd_reg.qa   <= s_tdata[127:96];
            cmd_reg.qb   <= s_tdata[159:128];
            cmd_reg.base <= '0;
        end
        if (ld) begin
            act2_reg  <= cmd_reg.act;
            stat2_reg <= stat1;
        end
        if (out_load) begin
            m_status_reg <= stat2_reg;
            m_mapped_reg <= (act2_reg == ACT_TRANSLATE) ? or_mapped : 32'd0;
            m_same_reg   <= (act2_reg == ACT_SAME) ? or_same : 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_same_reg, m_mapped_reg};
    assign m_tuser  = m_status_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for section_offset_translator: directed table, then random phases.
// Expected: section table model here, or a typed row's answer; depends on soot_pkg and RTL.
`timescale 1ns / 1ps

module tb_top;
    import soot_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int TABLE_DEPTH    = 16;
    localparam int PHASE_ITEMS    = 380;
    localparam int HOLD_AT        = 700;
    localparam int HOLD_CYCLES    = 300;
    localparam int CALM_FROM      = 1200;
    localparam int CALM_TO        = 1500;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 10;

    // One result as the block presents it
    typedef struct packed {
        status_t     st;
        logic [31:0] mapped;
        logic        same;
    } answer_t;

    // One row of the directed stimulus table
    typedef struct {
        act_t        act;
        logic [31:0] off;
        logic [31:0] va;
        logic [31:0] sz;
        logic [31:0] qa;
        logic [31:0] qb;
        bit          typed;
        answer_t     ans;
    } dir_row_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata   = '0;   // sect_file_offset, sect_virt_addr, sect_virt_size, qa, qb
    logic [1:0]   s_tuser   = '0;   // action
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [39:0]  m_tdata;          // mapped_addr, same_section, zero fill
    logic [1:0]   m_tuser;          // status

    // Section table model
    logic [31:0] sec_off [TABLE_DEPTH];
    logic [31:0] sec_va  [TABLE_DEPTH];
    logic [31:0] sec_sz  [TABLE_DEPTH];
    int          sec_count = 0;
    logic [31:0] base_reg  = '0;

    answer_t     pending_results[$];
    dir_row_t    dir_q[$];
    bit          cur_typed;
    answer_t     cur_answer;
    answer_t     no_answer;
    int          items_sent  = 0;
    int          errors      = 0;
    int          idle_cycles = 0;
    bit          calm        = 1'b0;
    bit          hold_go     = 1'b0;
    bit          hold_done   = 1'b0;
    answer_t     want;
    answer_t     got;
    answer_t     fresh;

    section_offset_translator #(
        .MAX_SECTIONS(TABLE_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic answer_t answer_of(status_t st);
        answer_t r;
        r.st     = st;
        r.mapped = '0;
        r.same   = 1'b0;
        return r;
    endfunction

    // Apply one item to the section table model and return its result
    function automatic answer_t section_table_step(act_t act, logic [31:0] off, logic [31:0] va,
                                                   logic [31:0] sz, logic [31:0] qa,
                                                   logic [31:0] qb);
        answer_t     r;
        int          pos;
        int          k;
        logic [33:0] lo;
        logic [33:0] hi;
        r = answer_of(ST_OK);
        case (act)
            ACT_CLEAR: begin
                sec_count = 0;
            end
            ACT_INSERT: begin
                if (sec_count >= TABLE_DEPTH) begin
                    r.st = ST_FULL;
                end else begin
                    // ties go after the existing entries
                    pos = 0;
                    while (pos < sec_count && sec_off[pos] <= off) pos++;
                    for (k = sec_count; k > pos; k--) begin
                        sec_off[k] = sec_off[k-1];
                        sec_va[k]  = sec_va[k-1];
                        sec_sz[k]  = sec_sz[k-1];
                    end
                    sec_off[pos] = off;
                    sec_va[pos]  = va;
                    sec_sz[pos]  = sz;
                    sec_count++;
                end
            end
            ACT_TRANSLATE: begin
                k = 0;
                while (k < sec_count && qa >= sec_off[k]) k++;
                if (k == 0) begin
                    r.st = ST_NOT_COVERED;
                end else begin
                    r.mapped = qa - sec_off[k-1] + sec_va[k-1] + base_reg;
                end
            end
            default: begin
                // ranges without wrap
                for (k = 0; k < sec_count; k++) begin
                    lo = {2'b00, sec_va[k]} + {2'b00, base_reg};
                    hi = lo + {2'b00, sec_sz[k]};
                    if ({2'b00, qa} >= lo && {2'b00, qa} < hi &&
                        {2'b00, qb} >= lo && {2'b00, qb} < hi) begin
                        r.same = 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Offsets drawn from a small pool now and then, to force ties
    function automatic logic [31:0] pick_offset();
        if ($urandom_range(0, 1) == 0) begin
            return $urandom_range(0, 15) << 12;
        end
        return pick_word();
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom_range(1, 65536);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(act_t act, logic [31:0] off, logic [31:0] va, logic [31:0] sz,
                           logic [31:0] qa, logic [31:0] qb, bit typed, status_t st);
        dir_row_t row;
        row.act   = act;
        row.off   = off;
        row.va    = va;
        row.sz    = sz;
        row.qa    = qa;
        row.qb    = qb;
        row.typed = typed;
        row.ans   = answer_of(st);
        dir_q.push_back(row);
    endtask

    // Offer one item from a falling edge, hold until its transfer, then maybe idle
    task automatic drive_item(act_t act, logic [31:0] off, logic [31:0] va, logic [31:0] sz,
                              logic [31:0] qa, logic [31:0] qb, bit typed, answer_t ans);
        calm       = (items_sent >= CALM_FROM && items_sent < CALM_TO);
        cur_typed  = typed;
        cur_answer = ans;
        s_tuser   <= act;
        s_tdata   <= {qb, qa, sz, va, off};
        s_tvalid  <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (items_sent == HOLD_AT) hold_go = 1'b1;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    endtask

    // Write image_base once every outstanding result has arrived
    task automatic write_base(logic [31:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        base_reg   = value;
    endtask

    // Random phase: mostly clear/insert/query runs, some noise
    task automatic run_random(int quota);
        int          stop;
        int          j;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] lo32;
        stop = items_sent + quota;
        while (items_sent < stop) begin
            if ($urandom_range(0, 99) < 15) begin
                drive_item(act_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                           $urandom, $urandom, 1'b0, no_answer);
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    drive_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                               1'b0, no_answer);
                end
                repeat ($urandom_range(1, 18)) begin
                    drive_item(ACT_INSERT, pick_offset(), pick_word(), pick_size(),
                               $urandom, $urandom, 1'b0, no_answer);
                end
                repeat ($urandom_range(2, 10)) begin
                    a = $urandom;
                    b = $urandom;
                    j = (sec_count > 0) ? $urandom_range(0, sec_count - 1) : 0;
                    if ($urandom_range(0, 1) == 0) begin
                        // aim at and around a section start
                        if (sec_count > 0) begin
                            case ($urandom_range(0, 3))
                                0:       a = sec_off[j];
                                1:       a = sec_off[j] - 1;
                                2:       a = sec_off[j] + $urandom_range(0, 8191);
                                default: a = $urandom;
                            endcase
                        end
                        drive_item(ACT_TRANSLATE, $urandom, $urandom, $urandom, a, b,
                                   1'b0, no_answer);
                    end else begin
                        // aim inside, at and past the edges of a section
                        if (sec_count > 0) begin
                            lo32 = sec_va[j] + base_reg;
                            a = lo32 + ((sec_sz[j] != 0) ? ($urandom % sec_sz[j]) : 32'h0);
                            case ($urandom_range(0, 3))
                                0:       b = lo32 + ((sec_sz[j] != 0) ?
                                                     ($urandom % sec_sz[j]) : 32'h0);
                                1:       b = lo32 + sec_sz[j] - 1;
                                2:       b = lo32 + sec_sz[j];
                                default: b = lo32 - 1;
                            endcase
                        end
                        drive_item(ACT_SAME, $urandom, $urandom, $urandom, a, b,
                                   1'b0, no_answer);
                    end
                end
            end
        end
    endtask

    // Receiver: random stalls, one long hold-off, a calm stretch
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_go && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 12);
            end
        end
    end

    // Check each result transfer, then record the expectation of each input transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.st     = status_t'(m_tuser);
                got.mapped = m_tdata[31:0];
                got.same   = m_tdata[32];
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result expected none got status %0d addr %h same %0d",
                             $time, got.st, got.mapped, got.same);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.st !== want.st) begin
                        $display("%0t: status expected %0d got %0d", $time, want.st, got.st);
                        errors++;
                    end
                    if (got.mapped !== want.mapped) begin
                        $display("%0t: mapped_addr expected %h got %h",
                                 $time, want.mapped, got.mapped);
                        errors++;
                    end
                    if (got.same !== want.same) begin
                        $display("%0t: same_section expected %0d got %0d",
                                 $time, want.same, got.same);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                fresh = section_table_step(act_t'(s_tuser), s_tdata[31:0], s_tdata[63:32],
                                           s_tdata[95:64], s_tdata[127:96], s_tdata[159:128]);
                pending_results.push_back(cur_typed ? cur_answer : fresh);
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        no_answer = answer_of(ST_OK);
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table, image_base still at its reset value
        add_row(ACT_TRANSLATE, 0, 0, 0, 32'h0000_0000, 0, 1'b1, ST_NOT_COVERED);
        add_row(ACT_TRANSLATE, 0, 0, 0, 32'hFFFF_FFFF, 0, 1'b1, ST_NOT_COVERED);
        add_row(ACT_SAME, 0, 0, 0, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK);
        add_row(ACT_INSERT, 32'h1000, 32'h2000, 32'h100, 0, 0, 1'b1, ST_OK);
        add_row(ACT_TRANSLATE, 0, 0, 0, 32'h0FFF, 0, 1'b1, ST_NOT_COVERED);
        add_row(ACT_TRANSLATE, 0, 0, 0, 32'h1000, 0, 1'b0, ST_OK);
        add_row(ACT_INSERT, 32'h1000, 32'h5000, 32'h10, 0, 0, 1'b1, ST_OK);
        add_row(ACT_TRANSLATE, 0, 0, 0, 32'h1004, 0, 1'b0, ST_OK);
        add_row(ACT_INSERT, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1'b1, ST_OK);
        add_row(ACT_INSERT, 32'hFFFF_FFFF, 32'h0, 32'h0, 0, 0, 1'b1, ST_OK);
        add_row(ACT_TRANSLATE, 0, 0, 0, 32'hFFFF_FFFF, 0, 1'b0, ST_OK);
        add_row(ACT_TRANSLATE, 0, 0, 0, 32'h0000_0000, 0, 1'b0, ST_OK);
        add_row(ACT_SAME, 0, 0, 0, 32'h2000, 32'h20FF, 1'b0, ST_OK);
        add_row(ACT_SAME, 0, 0, 0, 32'h20FF, 32'h2100, 1'b0, ST_OK);
        add_row(ACT_SAME, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, ST_OK);
        add_row(ACT_SAME, 0, 0, 0, 32'h0000_0000, 32'h0000_0000, 1'b0, ST_OK);
        // fill the remaining entries, then overflow
        for (int i = 0; i < TABLE_DEPTH - 4; i++) begin
            add_row(ACT_INSERT, (i + 2) << 16, i << 20, 32'h1_0000, 0, 0, 1'b0, ST_OK);
        end
        add_row(ACT_INSERT, 32'h8000, 32'h9000, 32'h10, 0, 0, 1'b1, ST_FULL);
        add_row(ACT_TRANSLATE, 0, 0, 0, 32'h1004, 0, 1'b0, ST_OK);
        add_row(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK);
        add_row(ACT_TRANSLATE, 0, 0, 0, 32'hFFFF_FFFF, 0, 1'b1, ST_NOT_COVERED);
        add_row(ACT_SAME, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK);

        foreach (dir_q[i]) begin
            drive_item(dir_q[i].act, dir_q[i].off, dir_q[i].va, dir_q[i].sz,
                       dir_q[i].qa, dir_q[i].qb, dir_q[i].typed, dir_q[i].ans);
        end

        // Random phases, each under its own image_base
        write_base(32'hFFFF_FFFF);
        run_random(PHASE_ITEMS);
        write_base(32'h8000_0000);
        run_random(PHASE_ITEMS);
        write_base($urandom);
        run_random(PHASE_ITEMS);
        write_base(32'h0040_0000);
        run_random(PHASE_ITEMS);
        write_base(32'h0000_0000);
        run_random(PHASE_ITEMS);
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for stray ones
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
